/* hdl/first_unique_value_tracker_core_macros.svh */
// Assertion macros for the first unique value tracker.
// Used by the top level; needs clk and arst_n in the including scope.
`ifndef FIRST_UNIQUE_VALUE_TRACKER_CORE_MACROS_SVH
`define FIRST_UNIQUE_VALUE_TRACKER_CORE_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define FUVT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a condition implies a consequence at the following clock edge.
`define FUVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/fuvt_pkg.sv */
// Shared types and constants for the first unique value tracker.
// Used by the table cell, the list cell and the top level.
package fuvt_pkg;

	localparam int VALUE_W = 32;
	localparam int TABLE_DEPTH = 64;
	localparam logic [VALUE_W-1:0] NONE_VALUE = {VALUE_W{1'b1}};

	typedef struct packed {
		logic cmp;
		logic upd;
		logic append;
	} fuvt_ctl_t;

endpackage

/* hdl/fuvt_seen_cell.sv */
// One entry of the table of seen values: stored value, valid bit and match flag.
// Depends on fuvt_pkg.
module fuvt_seen_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fuvt_pkg::fuvt_ctl_t              ctl,
	input  logic [fuvt_pkg::VALUE_W-1:0]     v,
	input  logic                             prev_valid,
	output logic                             valid,
	output logic                             match
);

	logic [fuvt_pkg::VALUE_W-1:0] value_q;
	logic                         valid_q;
	logic                         match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.cmp) begin
				match_q <= valid_q && (value_q == v);
			end
			if (ctl.upd && ctl.append && !valid_q && prev_valid) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd && ctl.append && !valid_q && prev_valid) begin
			value_q <= v;
		end
	end

	assign valid = valid_q;
	assign match = match_q;

endmodule

/* hdl/fuvt_list_cell.sv */
// One place of the arrival-ordered list of unique values.
// It closes up from its right neighbor or takes a new value. Depends on fuvt_pkg.
module fuvt_list_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fuvt_pkg::fuvt_ctl_t              ctl,
	input  logic [fuvt_pkg::VALUE_W-1:0]     v,
	input  logic                             prev_valid,
	input  logic [fuvt_pkg::VALUE_W-1:0]     next_value,
	input  logic                             next_valid,
	input  logic                             shift,
	output logic [fuvt_pkg::VALUE_W-1:0]     value,
	output logic                             valid,
	output logic                             match
);

	logic [fuvt_pkg::VALUE_W-1:0] value_q;
	logic                         valid_q;
	logic                         match_q;
	logic                         load;

	assign load = ctl.upd && !shift && ctl.append && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.cmp) begin
				match_q <= valid_q && (value_q == v);
			end
			if (ctl.upd && shift) begin
				valid_q <= next_valid;
			end else if (load) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd && shift) begin
			value_q <= next_value;
		end else if (load) begin
			value_q <= v;
		end
	end

	assign value = value_q;
	assign valid = valid_q;
	assign match = match_q;

endmodule

/* hdl/first_unique_value_tracker_core.sv */
// Top level of the first unique value tracker: control, cell rows and result register.
// Depends on fuvt_pkg, fuvt_seen_cell, fuvt_list_cell and the assertion macros.
//
//   channel | signals                                      | direction
//   in      | in_valid, in_ready, value                    | beat into block
//   out     | out_valid, out_ready, first_unique,          | beat out of block
//           | has_unique, table_full                       |
//
// Each beat passes through five states in order: acceptance, compare in every cell,
// a log-depth prefix for the list close-up, the cell update, and the result load.
// The result is loaded into the output register from the result step.
// Reset clears all valid bits at once; no clearing pass is needed.
// A stalled output holds the block in its result step until the slot frees.
`include "first_unique_value_tracker_core_macros.svh"

module first_unique_value_tracker_core #(
	parameter int TABLE_DEPTH = fuvt_pkg::TABLE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [fuvt_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [fuvt_pkg::VALUE_W-1:0] first_unique,
	output logic                                has_unique,
	output logic                                table_full
);

	localparam int LVL = $clog2(TABLE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_PFX,
		ST_UPD,
		ST_RES
	} state_t;

	state_t                        state_q;
	logic [fuvt_pkg::VALUE_W-1:0]  value_q;
	logic                          append_q;
	logic                          full_q;
	logic                          out_valid_q;
	logic [fuvt_pkg::VALUE_W-1:0]  first_unique_q;
	logic                          has_unique_q;
	logic                          table_full_q;
	logic [TABLE_DEPTH-1:0]        shift_q;

	fuvt_pkg::fuvt_ctl_t           ctl;
	logic [TABLE_DEPTH-1:0]        seen_valid;
	logic [TABLE_DEPTH-1:0]        seen_match;
	logic [TABLE_DEPTH-1:0]        list_valid;
	logic [TABLE_DEPTH-1:0]        list_match;
	logic [fuvt_pkg::VALUE_W-1:0]  list_value [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]        pfx [LVL+1];
	logic                          found;

	assign ctl.cmp    = (state_q == ST_CMP);
	assign ctl.upd    = (state_q == ST_UPD);
	assign ctl.append = append_q;

	genvar gi, gk;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			logic                         prev_seen;
			logic                         prev_list;
			logic [fuvt_pkg::VALUE_W-1:0] nxt_value;
			logic                         nxt_valid;

			if (gi == 0) begin : g_first
				assign prev_seen = 1'b1;
				assign prev_list = 1'b1;
			end else begin : g_rest
				assign prev_seen = seen_valid[gi-1];
				assign prev_list = list_valid[gi-1];
			end

			if (gi == TABLE_DEPTH - 1) begin : g_last
				assign nxt_value = fuvt_pkg::NONE_VALUE;
				assign nxt_valid = 1'b0;
			end else begin : g_inner
				assign nxt_value = list_value[gi+1];
				assign nxt_valid = list_valid[gi+1];
			end

			fuvt_seen_cell u_seen (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.v          (value_q),
				.prev_valid (prev_seen),
				.valid      (seen_valid[gi]),
				.match      (seen_match[gi])
			);

			fuvt_list_cell u_list (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.v          (value_q),
				.prev_valid (prev_list),
				.next_value (nxt_value),
				.next_valid (nxt_valid),
				.shift      (shift_q[gi]),
				.value      (list_value[gi]),
				.valid      (list_valid[gi]),
				.match      (list_match[gi])
			);
		end

		assign pfx[0] = list_match;
		for (gk = 0; gk < LVL; gk++) begin : g_lvl
			for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_bit
				if (gi >= (1 << gk)) begin : g_or
					assign pfx[gk+1][gi] = pfx[gk][gi] | pfx[gk][gi-(1<<gk)];
				end else begin : g_pass
					assign pfx[gk+1][gi] = pfx[gk][gi];
				end
			end
		end
	endgenerate

	assign found = |seen_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else if (state_q == ST_PFX) begin
			shift_q <= pfx[LVL];
		end else if (state_q == ST_IDLE) begin
			shift_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			append_q       <= 1'b0;
			full_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			value_q        <= '0;
			first_unique_q <= '0;
			has_unique_q   <= 1'b0;
			table_full_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_RES) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						value_q <= value;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_PFX;
				end
				ST_PFX: begin
					append_q <= !found && !seen_valid[TABLE_DEPTH-1];
					full_q   <= !found && seen_valid[TABLE_DEPTH-1];
					state_q  <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (!out_valid_q || out_ready) begin
						first_unique_q <= list_valid[0] ? list_value[0] : fuvt_pkg::NONE_VALUE;
						has_unique_q   <= list_valid[0];
						table_full_q   <= full_q;
						out_valid_q    <= 1'b1;
						append_q       <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign first_unique = first_unique_q;
	assign has_unique   = has_unique_q;
	assign table_full   = table_full_q;

	`FUVT_ASSERT_ALWAYS(a_list_le_seen, $countones(list_valid) <= $countones(seen_valid), "list longer than table")
	`FUVT_ASSERT_ALWAYS(a_seen_packed, (seen_valid & (seen_valid + 1'b1)) == '0, "table entries not packed")
	`FUVT_ASSERT_ALWAYS(a_list_packed, (list_valid & (list_valid + 1'b1)) == '0, "list entries not packed")
	`FUVT_ASSERT_NEXT(a_append_full, state_q == ST_PFX, !(append_q && full_q), "append while full")

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for first_unique_value_tracker_core: random stream values with
// random gaps on both channels, checked beat by beat against an in-bench tracker.
// Depends on fuvt_pkg and the RTL of the tracker core.
`timescale 1ns / 100ps

module tb_top;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int LONG_HOLD = 160;

	typedef struct packed {
		logic signed [fuvt_pkg::VALUE_W-1:0] first_unique;
		logic                                has_unique;
		logic                                table_full;
	} head_report_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic signed [fuvt_pkg::VALUE_W-1:0] value = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [fuvt_pkg::VALUE_W-1:0] first_unique;
	logic                                has_unique;
	logic                                table_full;

	// Tracker state as the block should hold it.
	logic [fuvt_pkg::VALUE_W-1:0] seen_vals [fuvt_pkg::TABLE_DEPTH];
	bit                           seen_rep [fuvt_pkg::TABLE_DEPTH];
	int                           seen_n = 0;
	logic [fuvt_pkg::VALUE_W-1:0] unique_order [fuvt_pkg::TABLE_DEPTH];
	int                           unique_n = 0;

	logic [fuvt_pkg::VALUE_W-1:0] stream_q [$];
	head_report_t                 predicted_heads [$];
	logic [fuvt_pkg::VALUE_W-1:0] pool_stored [$];
	logic [fuvt_pkg::VALUE_W-1:0] pool_dropped [$];

	bit in_fire = 1'b0;
	bit out_fire = 1'b0;
	bit in_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit rx_hold_req = 1'b0;
	int rx_hold_left = 0;
	int in_gap = 0;
	int out_wait = 0;
	int stall_cycles = 0;
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int dropped_seen = 0;
	int empty_seen = 0;

	first_unique_value_tracker_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.first_unique(first_unique),
		.has_unique  (has_unique),
		.table_full  (table_full)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic head_report_t track_value(logic [fuvt_pkg::VALUE_W-1:0] v);
		head_report_t r;
		int hit;
		int pos;
		int k;
		hit = -1;
		pos = -1;
		r.table_full = 1'b0;
		for (k = 0; k < seen_n; k++) begin
			if (hit < 0 && seen_vals[k] == v) begin
				hit = k;
			end
		end
		if (hit >= 0) begin
			if (!seen_rep[hit]) begin
				seen_rep[hit] = 1'b1;
				for (k = 0; k < unique_n; k++) begin
					if (pos < 0 && unique_order[k] == v) begin
						pos = k;
					end
				end
				if (pos >= 0) begin
					for (k = pos; k + 1 < unique_n; k++) begin
						unique_order[k] = unique_order[k + 1];
					end
					unique_n--;
				end
			end
		end else if (seen_n >= fuvt_pkg::TABLE_DEPTH) begin
			r.table_full = 1'b1;
		end else begin
			seen_vals[seen_n] = v;
			seen_rep[seen_n] = 1'b0;
			seen_n++;
			unique_order[unique_n] = v;
			unique_n++;
		end
		if (unique_n > 0) begin
			r.first_unique = unique_order[0];
			r.has_unique = 1'b1;
		end else begin
			r.first_unique = fuvt_pkg::NONE_VALUE;
			r.has_unique = 1'b0;
		end
		return r;
	endfunction

	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 31) == 0) begin
			calm = !calm;
		end
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic bit in_pool(logic [fuvt_pkg::VALUE_W-1:0] v);
		foreach (pool_stored[k]) begin
			if (pool_stored[k] == v) begin
				return 1'b1;
			end
		end
		foreach (pool_dropped[k]) begin
			if (pool_dropped[k] == v) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Draws a value never sent before and files it as stored or dropped,
	// following the order in which the block will see it.
	function automatic logic [fuvt_pkg::VALUE_W-1:0] fresh_value();
		logic [fuvt_pkg::VALUE_W-1:0] v;
		do begin
			if ($urandom_range(0, 3) == 0) begin
				v = $urandom_range(0, 31) - 16;
			end else begin
				v = $urandom;
			end
		end while (in_pool(v));
		if (pool_stored.size() < fuvt_pkg::TABLE_DEPTH) begin
			pool_stored = {pool_stored, v};
		end else begin
			pool_dropped = {pool_dropped, v};
		end
		return v;
	endfunction

	task automatic send_directed(logic [fuvt_pkg::VALUE_W-1:0] v);
		if (!in_pool(v)) begin
			pool_stored = {pool_stored, v};
		end
		stream_q = {stream_q, v};
	endtask

	task automatic wait_drained();
		while (stream_q.size() > 0 || in_valid || predicted_heads.size() > 0) begin
			@(posedge clk);
		end
	endtask

	always @(negedge clk) begin : sender
		logic offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			offer = in_valid && !in_fire;
			if (!offer) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (stream_q.size() > 0) begin
					value <= stream_q.pop_front();
					offer = 1'b1;
					in_gap = draw_gap(in_calm);
				end
			end
			in_valid <= offer;
		end
	end

	always @(negedge clk) begin : receiver
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_fire) begin
				out_wait = draw_gap(rx_calm);
			end
			if (rx_hold_left > 0) begin
				out_ready <= 1'b0;
			end else if (out_wait > 0) begin
				out_ready <= 1'b0;
				out_wait--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : receiver_hold
		if (rx_hold_req) begin
			rx_hold_left = LONG_HOLD;
			rx_hold_req = 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left--;
		end
	end

	always @(posedge clk) begin : monitor
		head_report_t want;
		if (arst_n) begin
			in_fire = in_valid && in_ready;
			out_fire = out_valid && out_ready;
			if (in_fire) begin
				predicted_heads = {predicted_heads, track_value(value)};
				items_sent++;
			end
			if (out_fire) begin
				results_seen++;
				if (predicted_heads.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Unexpected beat: first_unique=%h has_unique=%b table_full=%b",
							first_unique, has_unique, table_full);
					end
				end else begin
					want = predicted_heads.pop_front();
					if (want.table_full) begin
						dropped_seen++;
					end
					if (!want.has_unique) begin
						empty_seen++;
					end
					if (first_unique !== want.first_unique || has_unique !== want.has_unique
							|| table_full !== want.table_full) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Beat %0d: expected %h/%b/%b, got %h/%b/%b", results_seen,
								want.first_unique, want.has_unique, want.table_full,
								first_unique, has_unique, table_full);
						end
					end
				end
			end
			stall_cycles = (in_fire || out_fire) ? 0 : stall_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (stall_cycles >= STALL_LIMIT);
		$display("No beat moved for %0d cycles.", STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int n;
		int pick;
		logic [fuvt_pkg::VALUE_W-1:0] v;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A unique -1, both extremes and zero, then repeats that empty the list.
		send_directed(32'hFFFF_FFFF);
		send_directed(32'h7FFF_FFFF);
		send_directed(32'h8000_0000);
		send_directed(32'h0000_0000);
		send_directed(32'hFFFF_FFFF);
		send_directed(32'h7FFF_FFFF);
		send_directed(32'hFFFF_FFFF);
		send_directed(32'h8000_0000);
		send_directed(32'h0000_0000);
		send_directed(32'h0000_0000);
		send_directed(32'h5555_5555);
		send_directed(32'hAAAA_AAAA);
		send_directed(32'hAAAA_AAAA);
		send_directed(32'h1234_5678);
		send_directed(32'h5555_5555);
		wait_drained();

		// Fill the table slowly, mostly with repeats; the receiver holds off at first.
		for (n = 0; n < 380; n++) begin
			if ($urandom_range(0, 4) == 0) begin
				v = fresh_value();
			end else begin
				v = pool_stored[$urandom_range(0, pool_stored.size() - 1)];
			end
			stream_q = {stream_q, v};
		end
		@(negedge clk);
		rx_hold_req = 1'b1;
		wait_drained();

		// Table full: stored values, new values that get dropped, and dropped ones again.
		for (n = 0; n < 555; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 5 || (pick >= 8 && pool_dropped.size() == 0)) begin
				v = pool_stored[$urandom_range(0, pool_stored.size() - 1)];
			end else if (pick < 8) begin
				v = fresh_value();
			end else begin
				v = pool_dropped[$urandom_range(0, pool_dropped.size() - 1)];
			end
			stream_q = {stream_q, v};
		end
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d stream values and checked %0d result beats.", items_sent,
			results_seen);
		$display("%0d beats hit the full table, %0d had no unique value.", dropped_seen,
			empty_seen);
		if (mismatches == 0 && predicted_heads.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d results missing.", mismatches,
				predicted_heads.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
